### hw/rtl/stsc_pkg.sv
// Shared types, constants and helpers for the source token scanner.
// No dependencies; every other scanner file imports this package.
package stsc_pkg;

   // Result field widths are fixed
   localparam int OUT_BITS = 20;
   localparam int MAX_RES  = 4;
   localparam logic [OUT_BITS-1:0] OUT_MAX = '1;

   // Token kinds
   localparam logic [4:0] K_LPAREN     = 5'd0;
   localparam logic [4:0] K_RPAREN     = 5'd1;
   localparam logic [4:0] K_LBRACE     = 5'd2;
   localparam logic [4:0] K_RBRACE     = 5'd3;
   localparam logic [4:0] K_COMMA      = 5'd4;
   localparam logic [4:0] K_DOT        = 5'd5;
   localparam logic [4:0] K_MINUS      = 5'd6;
   localparam logic [4:0] K_PLUS       = 5'd7;
   localparam logic [4:0] K_SEMI       = 5'd8;
   localparam logic [4:0] K_STAR       = 5'd9;
   localparam logic [4:0] K_EQUAL      = 5'd10;
   localparam logic [4:0] K_SLASH      = 5'd11;
   localparam logic [4:0] K_NUMBER     = 5'd12;
   localparam logic [4:0] K_IDENT      = 5'd13;
   localparam logic [4:0] K_VAR        = 5'd14;
   localparam logic [4:0] K_IF         = 5'd15;
   localparam logic [4:0] K_WHILE      = 5'd16;
   localparam logic [4:0] K_DEFER      = 5'd17;
   localparam logic [4:0] K_PRINT      = 5'd18;
   localparam logic [4:0] K_EOF        = 5'd19;
   localparam logic [4:0] K_BAD_CHAR   = 5'd20;
   localparam logic [4:0] K_BAD_NUMBER = 5'd21;

   // Source characters
   localparam logic [7:0] CH_LPAREN = "(";
   localparam logic [7:0] CH_RPAREN = ")";
   localparam logic [7:0] CH_LBRACE = "{";
   localparam logic [7:0] CH_RBRACE = "}";
   localparam logic [7:0] CH_COMMA  = ",";
   localparam logic [7:0] CH_DOT    = ".";
   localparam logic [7:0] CH_MINUS  = "-";
   localparam logic [7:0] CH_PLUS   = "+";
   localparam logic [7:0] CH_SEMI   = ";";
   localparam logic [7:0] CH_STAR   = "*";
   localparam logic [7:0] CH_EQUAL  = "=";
   localparam logic [7:0] CH_SLASH  = "/";
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_ZERO   = "0";
   localparam logic [7:0] CH_NINE   = "9";
   localparam logic [7:0] CH_LO_A   = "a";
   localparam logic [7:0] CH_LO_Z   = "z";
   localparam logic [7:0] CH_UP_A   = "A";
   localparam logic [7:0] CH_UP_Z   = "Z";

   // Keyword spellings, first five bytes of a word packed big-endian
   localparam logic [39:0] KW_VAR   = 40'h0000766172;
   localparam logic [39:0] KW_IF    = 40'h0000006966;
   localparam logic [39:0] KW_WHILE = 40'h7768696C65;
   localparam logic [39:0] KW_DEFER = 40'h6465666572;
   localparam logic [39:0] KW_PRINT = 40'h7072696E74;

   typedef struct packed {
      logic [7:0] char_code;
      logic       is_last;
   } req_type;

   typedef struct packed {
      logic [4:0]          token_kind;
      logic [OUT_BITS-1:0] start_offset;
      logic [OUT_BITS-1:0] token_length;
      logic [OUT_BITS-1:0] line_number;
      logic                run_end;
   } token_type;

   // All tokens caused by one source byte; last_idx is count minus one
   typedef struct packed {
      logic [1:0]                  last_idx;
      token_type [MAX_RES-1:0]     tok;
   } bundle_type;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return ((c >= CH_LO_A) && (c <= CH_LO_Z)) || ((c >= CH_UP_A) && (c <= CH_UP_Z));
   endfunction

   // Saturate an internal position to the result field width
   function automatic logic [OUT_BITS-1:0] clamp_pos(input logic [32:0] v);
      return (v > 33'(OUT_MAX)) ? OUT_MAX : v[OUT_BITS-1:0];
   endfunction

   // Word kind from its prefix; the caller saturates the length at six
   function automatic logic [4:0] word_kind(input logic [39:0] prefix, input logic [2:0] len);
      logic [4:0] k;
      k = K_IDENT;
      if (len == 3'd3 && prefix == KW_VAR) k = K_VAR;
      else if (len == 3'd2 && prefix == KW_IF) k = K_IF;
      else if (len == 3'd5) begin
         if (prefix == KW_WHILE) k = K_WHILE;
         else if (prefix == KW_DEFER) k = K_DEFER;
         else if (prefix == KW_PRINT) k = K_PRINT;
      end
      return k;
   endfunction

endpackage

### hw/rtl/source_token_scanner.sv
// Source token scanner top level: front end, bundle queue, output stage.
// Uses stsc_pkg, stsc_front, stsc_queue and stsc_back.
//
// One source byte is taken per clock while the queue has room; each byte
// yields zero to four tokens, which are stored together as one queue entry
// and delivered one token per clock while rsp_pop is high. Bytes that yield
// at most one token therefore stream at one per cycle while rsp_pop is high;
// a byte that yields several tokens holds the output until its last token
// is popped. Up to QUEUE_DEPTH such bundles wait in the queue, with one more
// held in the output stage, before full rises. A token is registered in a
// queue entry, then in the output stage, before it appears on rsp. run_end
// marks the last token of each byte, and the byte flagged is_last always
// ends with an end-of-file token and resets positions to offset 0, line 1.
module source_token_scanner #(
   parameter int POSITION_BITS = 20,
   parameter int QUEUE_DEPTH   = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   output logic                 req_full,
   input  stsc_pkg::req_type    req,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output stsc_pkg::token_type  rsp
);
   import stsc_pkg::*;

   logic        bnd_push, q_full, q_valid, q_take;
   bundle_type  bnd, q_data;

   assign req_full = q_full;

   stsc_front #(.POSITION_BITS(POSITION_BITS)) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .q_full   (q_full),
      .req      (req),
      .bnd_push (bnd_push),
      .bnd      (bnd)
   );

   stsc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push_in (bnd_push),
      .wr_data (bnd),
      .full    (q_full),
      .take    (q_take),
      .q_valid (q_valid),
      .rd_data (q_data)
   );

   stsc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_data    (q_data),
      .take      (q_take),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp       (rsp)
   );

endmodule

### hw/rtl/stsc_front.sv
// Scanner front end: takes one source byte per transaction, advances the scan
// state and builds the bundle of tokens that byte completes. Uses stsc_pkg.
module stsc_front #(
   parameter int POSITION_BITS = 20
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   input  logic                  q_full,
   input  stsc_pkg::req_type     req,
   output logic                  bnd_push,
   output stsc_pkg::bundle_type  bnd
);
   import stsc_pkg::*;

   localparam int P = POSITION_BITS;
   localparam int NSLOT = 6;
   // Slot order follows emission order within one byte
   localparam int SL_CLOSE = 0;  // token closed by this byte
   localparam int SL_CDOT  = 1;  // point rescanned after a bad number
   localparam int SL_BEGIN = 2;  // single-byte token begun by this byte
   localparam int SL_FLUSH = 3;  // pending token flushed at end of source
   localparam int SL_FDOT  = 4;  // point flushed at end of source
   localparam int SL_EOF   = 5;

   typedef enum logic [6:0] {
      M_IDLE     = 7'b0000001,
      M_SLASH    = 7'b0000010,
      M_COMMENT  = 7'b0000100,
      M_NUM_INT  = 7'b0001000,
      M_NUM_DOT  = 7'b0010000,
      M_NUM_FRAC = 7'b0100000,
      M_WORD     = 7'b1000000
   } mode_type;

   mode_type      mode_ff, mode_in;
   logic [P-1:0]  start_ff, start_in;
   logic [P-1:0]  off_ff, off_in;
   logic [P-1:0]  line_ff, line_in;
   logic [39:0]   prefix_ff, prefix_in;
   logic [2:0]    wlen_ff, wlen_in;

   logic              accept;
   logic [7:0]        c;
   logic [P-1:0]      p, p_inc, dot;
   logic              do_begin;
   logic              punct;
   logic [4:0]        punct_k;
   logic [NSLOT-1:0]  slot_v;
   token_type         slot_t [NSLOT];
   logic [2:0]        n;

   function automatic logic [P-1:0] sat_inc(input logic [P-1:0] v);
      return (v == '1) ? v : v + 1'b1;
   endfunction

   function automatic token_type make_tok(input logic [4:0] kind, input logic [P-1:0] s,
                                          input logic [P-1:0] e, input logic [P-1:0] ln);
      token_type    t;
      logic [P-1:0] len;
      len = (e >= s) ? e - s : '0;
      t.token_kind   = kind;
      t.start_offset = clamp_pos(33'(s));
      t.token_length = clamp_pos(33'(len));
      t.line_number  = clamp_pos(33'(ln));
      t.run_end      = 1'b0;
      return t;
   endfunction

   assign accept = req_push && !q_full;
   assign c      = req.char_code;
   assign p      = off_ff;
   assign p_inc  = sat_inc(off_ff);
   assign dot    = (p > start_ff) ? p - 1'b1 : start_ff;

   // Single-byte punctuation decoder
   always_comb begin
      punct   = 1'b1;
      punct_k = K_BAD_CHAR;
      unique case (c)
         CH_LPAREN: punct_k = K_LPAREN;
         CH_RPAREN: punct_k = K_RPAREN;
         CH_LBRACE: punct_k = K_LBRACE;
         CH_RBRACE: punct_k = K_RBRACE;
         CH_COMMA:  punct_k = K_COMMA;
         CH_DOT:    punct_k = K_DOT;
         CH_MINUS:  punct_k = K_MINUS;
         CH_PLUS:   punct_k = K_PLUS;
         CH_SEMI:   punct_k = K_SEMI;
         CH_STAR:   punct_k = K_STAR;
         CH_EQUAL:  punct_k = K_EQUAL;
         default:   punct = 1'b0;
      endcase
   end

   // Scan step: mode transition, token slots, next state
   always_comb begin
      mode_in   = mode_ff;
      start_in  = start_ff;
      line_in   = line_ff;
      prefix_in = prefix_ff;
      wlen_in   = wlen_ff;
      off_in    = p_inc;
      do_begin  = 1'b0;
      slot_v    = '0;
      for (int i = 0; i < NSLOT; i++) slot_t[i] = '0;

      // close or extend the pending token
      unique case (mode_ff)
         M_SLASH: begin
            if (c == CH_SLASH) mode_in = M_COMMENT;
            else begin
               slot_v[SL_CLOSE] = 1'b1;
               slot_t[SL_CLOSE] = make_tok(K_SLASH, start_ff, sat_inc(start_ff), line_ff);
               do_begin = 1'b1;
            end
         end
         M_COMMENT: begin
            if (c == CH_LF) do_begin = 1'b1;
         end
         M_NUM_INT: begin
            if (c == CH_DOT) mode_in = M_NUM_DOT;
            else if (!is_digit(c)) begin
               slot_v[SL_CLOSE] = 1'b1;
               slot_t[SL_CLOSE] = make_tok(K_NUMBER, start_ff, p, line_ff);
               do_begin = 1'b1;
            end
         end
         M_NUM_DOT: begin
            if (is_digit(c)) mode_in = M_NUM_FRAC;
            else begin
               slot_v[SL_CLOSE] = 1'b1;
               slot_t[SL_CLOSE] = make_tok(K_BAD_NUMBER, start_ff, dot, line_ff);
               slot_v[SL_CDOT]  = 1'b1;
               slot_t[SL_CDOT]  = make_tok(K_DOT, dot, sat_inc(dot), line_ff);
               do_begin = 1'b1;
            end
         end
         M_NUM_FRAC: begin
            if (c == CH_DOT) begin
               // second point: bad number, then the point itself
               slot_v[SL_CLOSE] = 1'b1;
               slot_t[SL_CLOSE] = make_tok(K_BAD_NUMBER, start_ff, p, line_ff);
               slot_v[SL_CDOT]  = 1'b1;
               slot_t[SL_CDOT]  = make_tok(K_DOT, p, p_inc, line_ff);
               mode_in = M_IDLE;
            end else if (!is_digit(c)) begin
               slot_v[SL_CLOSE] = 1'b1;
               slot_t[SL_CLOSE] = make_tok(K_NUMBER, start_ff, p, line_ff);
               do_begin = 1'b1;
            end
         end
         M_WORD: begin
            if (is_alpha(c) || is_digit(c)) begin
               if (wlen_ff < 3'd5) prefix_in = {prefix_ff[31:0], c};
               if (wlen_ff != 3'd6) wlen_in = wlen_ff + 3'd1;
            end else begin
               slot_v[SL_CLOSE] = 1'b1;
               slot_t[SL_CLOSE] = make_tok(word_kind(prefix_ff, wlen_ff), start_ff, p,
                                           line_ff);
               do_begin = 1'b1;
            end
         end
         default: do_begin = 1'b1;
      endcase

      // start a fresh token with this byte
      if (do_begin) begin
         start_in = p;
         mode_in  = M_IDLE;
         if (c == CH_SLASH) mode_in = M_SLASH;
         else if (c == CH_LF) line_in = sat_inc(line_ff);
         else if (is_digit(c)) mode_in = M_NUM_INT;
         else if (is_alpha(c)) begin
            mode_in   = M_WORD;
            prefix_in = {32'd0, c};
            wlen_in   = 3'd1;
         end else if (c != CH_SPACE && c != CH_TAB && c != CH_CR) begin
            slot_v[SL_BEGIN] = 1'b1;
            slot_t[SL_BEGIN] = make_tok(punct ? punct_k : K_BAD_CHAR, p, p_inc, line_ff);
         end
      end

      // end of source: flush the pending token, then end-of-file
      if (req.is_last) begin
         unique case (mode_in)
            M_SLASH: begin
               slot_v[SL_FLUSH] = 1'b1;
               slot_t[SL_FLUSH] = make_tok(K_SLASH, start_in, sat_inc(start_in), line_in);
            end
            M_NUM_INT, M_NUM_FRAC: begin
               slot_v[SL_FLUSH] = 1'b1;
               slot_t[SL_FLUSH] = make_tok(K_NUMBER, start_in, p_inc, line_in);
            end
            M_NUM_DOT: begin
               slot_v[SL_FLUSH] = 1'b1;
               slot_t[SL_FLUSH] = make_tok(K_BAD_NUMBER, start_in, p, line_in);
               slot_v[SL_FDOT]  = 1'b1;
               slot_t[SL_FDOT]  = make_tok(K_DOT, p, p_inc, line_in);
            end
            M_WORD: begin
               slot_v[SL_FLUSH] = 1'b1;
               slot_t[SL_FLUSH] = make_tok(word_kind(prefix_in, wlen_in), start_in, p_inc,
                                           line_in);
            end
            default: ;
         endcase
         slot_v[SL_EOF] = 1'b1;
         slot_t[SL_EOF] = make_tok(K_EOF, p_inc, p_inc, line_in);
         // next source starts from scratch
         mode_in   = M_IDLE;
         start_in  = '0;
         off_in    = '0;
         line_in   = P'(1);
         prefix_in = '0;
         wlen_in   = '0;
      end
   end

   // Pack valid slots in order into the bundle
   always_comb begin
      bnd = '0;
      n   = '0;
      for (int i = 0; i < NSLOT; i++) begin
         if (slot_v[i] && n < 3'd4) begin
            bnd.tok[n[1:0]] = slot_t[i];
            n = n + 3'd1;
         end
      end
      bnd.last_idx = 2'(n - 3'd1);
      bnd.tok[bnd.last_idx].run_end = 1'b1;
      bnd_push = accept && (n != 3'd0);
   end

   // Scan state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= M_IDLE;
         start_ff  <= '0;
         off_ff    <= '0;
         line_ff   <= P'(1);
         prefix_ff <= '0;
         wlen_ff   <= '0;
      end else if (accept) begin
         mode_ff   <= mode_in;
         start_ff  <= start_in;
         off_ff    <= off_in;
         line_ff   <= line_in;
         prefix_ff <= prefix_in;
         wlen_ff   <= wlen_in;
      end
   end

endmodule

### hw/rtl/stsc_queue.sv
// Bundle queue between scanner front end and token output stage.
// Uses stsc_pkg for the bundle type; DEPTH must be a power of two.
module stsc_queue #(
   parameter int DEPTH = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_in,
   input  stsc_pkg::bundle_type  wr_data,
   output logic                  full,
   input  logic                  take,
   output logic                  q_valid,
   output stsc_pkg::bundle_type  rd_data
);
   import stsc_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   bundle_type       store_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             rd;

   assign full    = (count_ff == CW'(DEPTH));
   assign q_valid = (count_ff != '0);
   assign rd      = take && q_valid;
   assign rd_data = store_ff[rd_ptr_ff];

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = push_in ? AW'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = rd ? AW'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push_in && !rd) count_in = count_ff + 1'b1;
      else if (rd && !push_in) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (push_in) store_ff[wr_ptr_ff] <= wr_data;
   end

endmodule

### hw/rtl/stsc_back.sv
// Token output stage: holds one bundle and hands its tokens out one per
// transaction in order. Uses stsc_pkg for bundle and token types.
module stsc_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   input  stsc_pkg::bundle_type  q_data,
   output logic                  take,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output stsc_pkg::token_type   rsp
);
   import stsc_pkg::*;

   bundle_type  cur_ff, cur_in;
   logic        valid_ff, valid_in;
   logic [1:0]  idx_ff, idx_in;
   logic        advance, load_slot;

   assign rsp_empty = !valid_ff;
   assign rsp       = cur_ff.tok[idx_ff];
   assign advance   = rsp_pop && valid_ff;
   assign load_slot = !valid_ff || (advance && idx_ff == cur_ff.last_idx);
   assign take      = load_slot && q_valid;

   // Step through the held bundle, refill when it is used up
   always_comb begin
      cur_in   = cur_ff;
      valid_in = valid_ff;
      idx_in   = idx_ff;
      if (load_slot) begin
         valid_in = q_valid;
         cur_in   = q_data;
         idx_in   = '0;
      end else if (advance) begin
         idx_in = idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

endmodule

### hw/rtl/stsc_checker.sv
// Port-level checks for the source token scanner, bound to the top level.
// Uses stsc_pkg for token kinds and port types.
module stsc_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_push,
   input logic                 req_full,
   input stsc_pkg::req_type    req,
   input logic                 rsp_empty,
   input logic                 rsp_pop,
   input stsc_pkg::token_type  rsp
);
   import stsc_pkg::*;

   // Nothing is offered right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("token offered right after reset");

   // Lines count from one
   a_line_nonzero: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> rsp.line_number != '0)
      else $error("token with line number zero");

   // End-of-file is empty and closes its byte's run
   a_eof_shape: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp.token_kind == K_EOF) |-> (rsp.token_length == '0 && rsp.run_end))
      else $error("malformed end-of-file token");

   // A stalled token holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp)))
      else $error("waiting token changed or dropped");

   // A refused byte stays offered unchanged
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      (req_push && req_full) |=> (req_push && $stable(req)))
      else $error("refused source byte changed or withdrawn");

endmodule

bind source_token_scanner stsc_checker u_stsc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_push  (req_push),
   .req_full  (req_full),
   .req       (req),
   .rsp_empty (rsp_empty),
   .rsp_pop   (rsp_pop),
   .rsp       (rsp)
);
